FILE: design/mtlp_pkg.sv
// Shared widths and result codes for the memory trace line parser.
// No dependencies; the channel interfaces refer to it and the top level imports it.
package mtlp_pkg;

   localparam int SIZE_BITS = 32;
   localparam int LINE_BITS = 32;

   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 64;
   localparam int OSIZE_W  = 32;
   localparam int OLINE_W  = 32;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [KIND_W-1:0]   kind_type;

   localparam status_type STATUS_VALID = 2'd0;
   localparam status_type STATUS_SKIP  = 2'd1;
   localparam status_type STATUS_BAD   = 2'd2;

   localparam kind_type KIND_READ  = 2'd0;
   localparam kind_type KIND_WRITE = 2'd1;
   localparam kind_type KIND_FETCH = 2'd2;

endpackage

FILE: design/mtlp_channels.sv
// Valid/ready channel interfaces for the trace characters and the parsed lines.
// Depends on mtlp_pkg for field widths.
interface mtlp_req_if;
   logic                          valid;
   logic                          ready;
   logic [mtlp_pkg::CHAR_W-1:0]   ch;
   logic                          end_of_line;

   modport source (output valid, output ch, output end_of_line, input ready);
   modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface mtlp_rsp_if;
   logic                          valid;
   logic                          ready;
   mtlp_pkg::status_type          line_status;
   mtlp_pkg::kind_type            access_kind;
   logic [mtlp_pkg::ADDR_W-1:0]   access_address;
   logic [mtlp_pkg::OSIZE_W-1:0]  access_size;
   logic [mtlp_pkg::OLINE_W-1:0]  line_index;

   modport source (output valid, output line_status, output access_kind,
                   output access_address, output access_size, output line_index,
                   input ready);
   modport sink   (input valid, input line_status, input access_kind,
                   input access_address, input access_size, input line_index,
                   output ready);
endinterface

FILE: design/memory_trace_line_parser.sv
// Memory trace line parser: one character item in, one parsed line item out per line end.
// A line's end-of-line item passes the input register, and its result then loads into the
// result register. Throughput: one item per cycle; an end-of-line item waits only while
// the result register still holds an untaken item. Synchronous active-high reset clears
// the parse state, the line counter and both valid flags. Depends on mtlp_pkg and channels.
module memory_trace_line_parser (
   input logic        clock,
   input logic        reset,
   mtlp_req_if.sink   req,
   mtlp_rsp_if.source rsp
);
   import mtlp_pkg::*;

   // Parse phases of the current line. A malformed line parks in the tail phase
   // with the bad flag set, so nothing after the error can change the outcome.
   localparam int PHASE_W = 4;
   localparam logic [PHASE_W-1:0] PH_LEAD    = 4'd0;
   localparam logic [PHASE_W-1:0] PH_COMMENT = 4'd1;
   localparam logic [PHASE_W-1:0] PH_OP      = 4'd2;
   localparam logic [PHASE_W-1:0] PH_GAP1    = 4'd3;
   localparam logic [PHASE_W-1:0] PH_ADDR    = 4'd4;
   localparam logic [PHASE_W-1:0] PH_ADDR_X  = 4'd5;
   localparam logic [PHASE_W-1:0] PH_GAP2    = 4'd6;
   localparam logic [PHASE_W-1:0] PH_SIZE    = 4'd7;
   localparam logic [PHASE_W-1:0] PH_TAIL    = 4'd8;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;
   localparam logic [CHAR_W-1:0] CH_UP_I    = 8'h49;
   localparam logic [CHAR_W-1:0] CH_UP_L    = 8'h4C;
   localparam logic [CHAR_W-1:0] CH_UP_M    = 8'h4D;
   localparam logic [CHAR_W-1:0] CH_UP_S    = 8'h53;
   localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_F    = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LO_I    = 8'h69;
   localparam logic [CHAR_W-1:0] CH_LO_L    = 8'h6C;
   localparam logic [CHAR_W-1:0] CH_LO_M    = 8'h6D;
   localparam logic [CHAR_W-1:0] CH_LO_S    = 8'h73;
   localparam logic [CHAR_W-1:0] CH_LO_X    = 8'h78;
   // Subtracting these leaves the hex value of a letter digit in the low nibble.
   localparam logic [CHAR_W-1:0] HEX_UP_BIAS = 8'h37;
   localparam logic [CHAR_W-1:0] HEX_LO_BIAS = 8'h57;

   localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

   // Input register stage.
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] ch_ff;
   logic              eol_ff;

   // Parse state.
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   kind_type             kind_ff, kind_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 bad_ff, bad_in;
   logic                 pend_ff, pend_in;
   logic [LINE_BITS-1:0] line_ff, line_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   kind_type             okind_ff, okind_in;
   logic [ADDR_W-1:0]    oaddr_ff, oaddr_in;
   logic [OSIZE_W-1:0]   osize_ff, osize_in;
   logic [OLINE_W-1:0]   oline_ff, oline_in;

   logic accept, advance, out_free, load_rsp;

   // Character classes of the registered character.
   logic                 is_sep, is_ws, is_digit, hex_ok, is_x;
   logic [3:0]           hex_val;
   logic [CHAR_W-1:0]    hex_diff;
   logic                 addr_ovf, size_ovf;
   logic [ADDR_W-1:0]    addr_shift;
   logic [SIZE_BITS+3:0] size_wide, size_prod;
   logic                 addr_step, size_step, line_ok;

   // Handshakes. A character moves on every cycle; a line end moves only when the
   // result register is empty or being emptied in the same cycle.
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && (!eol_ff || out_free);
   assign load_rsp  = advance && eol_ff;
   assign req.ready = !in_valid_ff || advance;
   assign accept    = req.valid && req.ready;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp.ready);

   assign is_sep   = (ch_ff == CH_SPACE) || (ch_ff == CH_TAB);
   assign is_ws    = is_sep || ((ch_ff >= CH_LF) && (ch_ff <= CH_CR));
   assign is_digit = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
   assign is_x     = (ch_ff == CH_LO_X) || (ch_ff == CH_UP_X);

   always_comb begin
      hex_ok   = 1'b1;
      hex_diff = ch_ff - CH_ZERO;
      priority if (is_digit) begin
         hex_diff = ch_ff - CH_ZERO;
      end else if ((ch_ff >= CH_LO_A) && (ch_ff <= CH_LO_F)) begin
         hex_diff = ch_ff - HEX_LO_BIAS;
      end else if ((ch_ff >= CH_UP_A) && (ch_ff <= CH_UP_F)) begin
         hex_diff = ch_ff - HEX_UP_BIAS;
      end else begin
         hex_ok = 1'b0;
      end
   end
   assign hex_val = hex_diff[3:0];

   // Address: shifting in another nibble while the top nibble is nonzero would push bits out of the word.
   assign addr_ovf   = |addr_ff[ADDR_W-1:ADDR_W-4];
   assign addr_shift = {addr_ff[ADDR_W-5:0], hex_val};

   // Size: times ten is two shifted copies added; any carry into the top four
   // bits means the value no longer fits in SIZE_BITS.
   assign size_wide = {4'b0000, size_ff};
   assign size_prod = (size_wide << 3) + (size_wide << 1)
                      + {{SIZE_BITS{1'b0}}, hex_val};
   assign size_ovf  = |size_prod[SIZE_BITS+3:SIZE_BITS];

   always_comb begin
      phase_in  = phase_ff;
      addr_in   = addr_ff;
      size_in   = size_ff;
      kind_in   = kind_ff;
      cnt_in    = cnt_ff;
      bad_in    = bad_ff;
      pend_in   = pend_ff;
      line_in   = line_ff;
      addr_step = 1'b0;
      size_step = 1'b0;
      if (advance) begin
         if (eol_ff) begin
            // Line end: start the next line from scratch.
            phase_in = PH_LEAD;
            addr_in  = '0;
            size_in  = '0;
            kind_in  = KIND_READ;
            cnt_in   = 2'd0;
            bad_in   = 1'b0;
            pend_in  = 1'b0;
            line_in  = line_ff + LINE_ONE;
         end else begin
            unique case (phase_ff)
               PH_LEAD: begin
                  if (is_ws) begin
                     phase_in = PH_LEAD;
                  end else if (ch_ff == CH_HASH) begin
                     phase_in = PH_COMMENT;
                  end else if ((ch_ff == CH_UP_L) || (ch_ff == CH_LO_L)) begin
                     kind_in  = KIND_READ;
                     phase_in = PH_OP;
                  end else if ((ch_ff == CH_UP_S) || (ch_ff == CH_LO_S) ||
                               (ch_ff == CH_UP_M) || (ch_ff == CH_LO_M)) begin
                     kind_in  = KIND_WRITE;
                     phase_in = PH_OP;
                  end else if ((ch_ff == CH_UP_I) || (ch_ff == CH_LO_I)) begin
                     kind_in  = KIND_FETCH;
                     phase_in = PH_OP;
                  end else begin
                     bad_in   = 1'b1;
                     phase_in = PH_TAIL;
                  end
               end
               PH_OP: begin
                  if (is_sep) begin
                     phase_in = PH_GAP1;
                  end else begin
                     bad_in   = 1'b1;
                     phase_in = PH_TAIL;
                  end
               end
               PH_GAP1: begin
                  if (!is_sep) begin
                     if (is_ws) begin
                        bad_in   = 1'b1;
                        phase_in = PH_TAIL;
                     end else begin
                        addr_step = 1'b1;
                     end
                  end
               end
               PH_ADDR, PH_ADDR_X: begin
                  if (!is_sep && is_ws) begin
                     bad_in   = 1'b1;
                     phase_in = PH_TAIL;
                  end else begin
                     addr_step = 1'b1;
                  end
               end
               PH_GAP2: begin
                  if (!is_ws) begin
                     size_step = 1'b1;
                  end
               end
               PH_SIZE: begin
                  size_step = 1'b1;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase

            if (addr_step) begin
               if (is_sep) begin
                  if (phase_ff == PH_ADDR_X) begin
                     bad_in   = 1'b1;
                     phase_in = PH_TAIL;
                  end else begin
                     phase_in = PH_GAP2;
                  end
               end else if ((cnt_ff == 2'd1) && (addr_ff == '0) && is_x) begin
                  // "0x" prefix: a hex digit must still follow.
                  phase_in = PH_ADDR_X;
                  cnt_in   = 2'd2;
               end else if (!hex_ok || addr_ovf) begin
                  bad_in   = 1'b1;
                  phase_in = PH_TAIL;
               end else begin
                  addr_in  = addr_shift;
                  phase_in = PH_ADDR;
                  if (cnt_ff != 2'd3) begin
                     cnt_in = cnt_ff + 2'd1;
                  end
               end
            end

            if (size_step) begin
               if (is_sep) begin
                  // After trailing odd whitespace only more whitespace may come.
                  if (!pend_ff) begin
                     phase_in = PH_TAIL;
                  end
               end else if (is_ws) begin
                  pend_in = 1'b1;
               end else if (pend_ff || !is_digit || size_ovf) begin
                  bad_in   = 1'b1;
                  phase_in = PH_TAIL;
               end else begin
                  size_in  = size_prod[SIZE_BITS-1:0];
                  phase_in = PH_SIZE;
               end
            end
         end
      end
   end

   // Result of the line being closed, taken from the state before the line end.
   assign line_ok = !bad_ff && ((phase_ff == PH_SIZE) || (phase_ff == PH_TAIL))
                    && (size_ff != '0);

   always_comb begin
      if ((phase_ff == PH_LEAD) || (phase_ff == PH_COMMENT)) begin
         status_in = STATUS_SKIP;
      end else if (line_ok) begin
         status_in = STATUS_VALID;
      end else begin
         status_in = STATUS_BAD;
      end
      okind_in = line_ok ? kind_ff : KIND_READ;
      oaddr_in = line_ok ? addr_ff : '0;
      osize_in = line_ok ? OSIZE_W'(size_ff) : '0;
      oline_in = OLINE_W'(line_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LEAD;
         addr_ff      <= '0;
         size_ff      <= '0;
         kind_ff      <= KIND_READ;
         cnt_ff       <= 2'd0;
         bad_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         line_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         addr_ff      <= addr_in;
         size_ff      <= size_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         bad_ff       <= bad_in;
         pend_ff      <= pend_in;
         line_ff      <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff  <= req.ch;
         eol_ff <= req.end_of_line;
      end
      if (load_rsp) begin
         status_ff <= status_in;
         okind_ff  <= okind_in;
         oaddr_ff  <= oaddr_in;
         osize_ff  <= osize_in;
         oline_ff  <= oline_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.line_status    = status_ff;
   assign rsp.access_kind    = okind_ff;
   assign rsp.access_address = oaddr_ff;
   assign rsp.access_size    = osize_ff;
   assign rsp.line_index     = oline_ff;

`ifndef SYNTHESIS
   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (phase_ff == PH_LEAD) && !bad_ff && !pend_ff && (cnt_ff == 2'd0))
      else $error("parse state not cleared after a line end");

   a_bad_parks: assert property (@(posedge clock) disable iff (reset)
      bad_ff |-> (phase_ff == PH_TAIL))
      else $error("malformed line left the tail phase");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != STATUS_VALID)) |->
         ((okind_ff == KIND_READ) && (oaddr_ff == '0) && (osize_ff == '0)))
      else $error("fields of a non-valid line are not zero");

   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(load_rsp))
      else $error("result appeared without a line end");
`endif

endmodule
